[src/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg: shared constants for the delta-list timer queue
// Command codes, result event codes and fixed field widths.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DELAY_W = 32;
    localparam int TICK_W  = 32;
    localparam int EVENT_W = 2;

    typedef logic [EVENT_W-1:0] t_event;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // result event codes
    localparam t_event EV_ADD_OK = 2'd0;
    localparam t_event EV_REJECT = 2'd1;
    localparam t_event EV_TICK   = 2'd2;
    localparam t_event EV_WAKE   = 2'd3;

endpackage

[src/delta_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// delta_timer_queue_unit: sleep-timer queue kept as a sorted delta list
// Adds insert a timer by delay, ticks age the head and wake expired entries.
// ----------------------------------------------------------------------------
// The queue holds up to TIMERS entries in a circular buffer RAM with one
// write and one registered read port; removal from the head only moves the
// head pointer. One beat is processed at a time and o_ready is high only
// while the sequencer is idle. An add walks the entries that expire before
// it, one RAM read per entry walked through the single read port; when it
// lands ahead of an existing entry it shortens that successor, primes the
// read and moves each later entry up a slot (one RAM read and one write
// each), then it inserts the new entry and gives the result. A full queue
// answers with a reject without touching the RAM. A tick on an empty queue
// gives its result without a RAM read; otherwise it ages the head entry,
// and each wake reads the next head entry to decide whether that wake is
// the last one. A result beat is held until i_ready takes it.
// ----------------------------------------------------------------------------
module delta_timer_queue_unit
    import dtq_pkg::*;
#(
    parameter int TIMERS       = 16,
    parameter int PROCESS_BITS = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [PROCESS_BITS-1:0] i_process_id,
    input  logic [DELAY_W-1:0]      i_delay,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [EVENT_W-1:0]      o_event_res,
    output logic [PROCESS_BITS-1:0] o_woken_id,
    output logic [TICK_W-1:0]       o_tick_count,
    output logic                    o_last
);

    localparam int IDXW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNTW = $clog2(TIMERS + 1);
    localparam int SUMW = CNTW + 1;
    localparam int MW   = PROCESS_BITS + DELAY_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WALK  = 4'd1;
    localparam logic [3:0] S_SHRD  = 4'd2;
    localparam logic [3:0] S_SHWR  = 4'd3;
    localparam logic [3:0] S_INS   = 4'd4;
    localparam logic [3:0] S_TDEC  = 4'd5;
    localparam logic [3:0] S_TCHK  = 4'd6;
    localparam logic [3:0] S_TNEXT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // map a list position to a RAM address
    function automatic logic [IDXW-1:0] f_phys(input logic [IDXW-1:0] head,
                                               input logic [CNTW-1:0] off);
        logic [SUMW-1:0] s;
        s = SUMW'(head) + SUMW'(off);
        if (s >= SUMW'(TIMERS)) begin
            s = s - SUMW'(TIMERS);
        end
        return s[IDXW-1:0];
    endfunction

    // control registers
    logic [3:0]              r_state, n_state;
    logic [CNTW-1:0]         r_cnt, n_cnt;
    logic [IDXW-1:0]         r_head, n_head;
    logic [TICK_W-1:0]       r_tick, n_tick;
    logic                    r_ov, n_ov;
    logic                    r_cont, n_cont;
    // working and payload registers
    logic [CNTW-1:0]         r_pos, n_pos;
    logic [CNTW-1:0]         r_idx, n_idx;
    logic [DELAY_W-1:0]      r_rem, n_rem;
    logic [PROCESS_BITS-1:0] r_id, n_id;
    logic [PROCESS_BITS-1:0] r_pend, n_pend;
    t_event                  r_oev, n_oev;
    logic [PROCESS_BITS-1:0] r_oid, n_oid;
    logic                    r_olast, n_olast;

    // list RAM
    logic [MW-1:0]           r_mem [TIMERS];
    logic [MW-1:0]           r_rd;
    logic                    mem_we;
    logic [IDXW-1:0]         mem_wa;
    logic [MW-1:0]           mem_wd;
    logic [IDXW-1:0]         mem_ra;

    logic [DELAY_W-1:0]      rd_delta;
    logic [PROCESS_BITS-1:0] rd_owner;
    logic [DELAY_W:0]        rem_minus_d;
    logic [DELAY_W-1:0]      d_minus_rem;
    logic [DELAY_W-1:0]      dec_delta;
    logic                    walk_on;
    logic [IDXW-1:0]         head_inc;

    assign rd_delta    = r_rd[DELAY_W-1:0];
    assign rd_owner    = r_rd[MW-1:DELAY_W];
    assign rem_minus_d = {1'b0, r_rem} - {1'b0, rd_delta};
    assign d_minus_rem = rd_delta - r_rem;
    assign dec_delta   = rd_delta - 1'b1;
    assign walk_on     = !rem_minus_d[DELAY_W] && (rem_minus_d[DELAY_W-1:0] != '0);
    assign head_inc    = (r_head == IDXW'(TIMERS - 1)) ? '0 : r_head + 1'b1;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_tick  = r_tick;
        n_ov    = r_ov;
        n_cont  = r_cont;
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_id    = r_id;
        n_pend  = r_pend;
        n_oev   = r_oev;
        n_oid   = r_oid;
        n_olast = r_olast;
        mem_we  = 1'b0;
        mem_wa  = f_phys(r_head, r_pos);
        mem_wd  = {r_id, r_rem};
        mem_ra  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_ADD) begin
                        if (r_cnt == CNTW'(TIMERS)) begin
                            n_ov    = 1'b1;
                            n_oev   = EV_REJECT;
                            n_oid   = '0;
                            n_olast = 1'b1;
                            n_cont  = 1'b0;
                            n_state = S_OUT;
                        end else begin
                            n_id  = i_process_id;
                            n_rem = (i_delay == '0) ? DELAY_W'(1) : i_delay;
                            n_pos = '0;
                            if (r_cnt == '0) begin
                                n_state = S_INS;
                            end else begin
                                mem_ra  = r_head;
                                n_state = S_WALK;
                            end
                        end
                    end else begin
                        n_tick = r_tick + 1'b1;
                        if (r_cnt == '0) begin
                            n_ov    = 1'b1;
                            n_oev   = EV_TICK;
                            n_oid   = '0;
                            n_olast = 1'b1;
                            n_cont  = 1'b0;
                            n_state = S_OUT;
                        end else begin
                            mem_ra  = r_head;
                            n_state = S_TDEC;
                        end
                    end
                end
            end
            // walk the list while the running remainder exceeds the entry delta
            S_WALK: begin
                if (walk_on) begin
                    n_rem = rem_minus_d[DELAY_W-1:0];
                    n_pos = r_pos + 1'b1;
                    if (r_pos + 1'b1 == r_cnt) begin
                        n_state = S_INS;
                    end else begin
                        mem_ra = f_phys(r_head, r_pos + 1'b1);
                    end
                end else begin
                    // shorten the successor by the new entry's remainder
                    mem_we  = 1'b1;
                    mem_wa  = f_phys(r_head, r_pos);
                    mem_wd  = {rd_owner, d_minus_rem};
                    n_idx   = r_cnt;
                    n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                mem_ra  = f_phys(r_head, r_idx - 1'b1);
                n_state = S_SHWR;
            end
            // move entries up one slot, reading the next while writing this one
            S_SHWR: begin
                mem_we = 1'b1;
                mem_wa = f_phys(r_head, r_idx);
                mem_wd = r_rd;
                n_idx  = r_idx - 1'b1;
                if (r_idx - 1'b1 > r_pos) begin
                    mem_ra = f_phys(r_head, r_idx - 2'd2);
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                mem_we  = 1'b1;
                mem_wa  = f_phys(r_head, r_pos);
                mem_wd  = {r_id, r_rem};
                n_cnt   = r_cnt + 1'b1;
                n_ov    = 1'b1;
                n_oev   = EV_ADD_OK;
                n_oid   = '0;
                n_olast = 1'b1;
                n_cont  = 1'b0;
                n_state = S_OUT;
            end
            // age the head entry
            S_TDEC: begin
                mem_we = 1'b1;
                mem_wa = r_head;
                mem_wd = {rd_owner, dec_delta};
                if (dec_delta != '0) begin
                    n_ov    = 1'b1;
                    n_oev   = EV_TICK;
                    n_oid   = '0;
                    n_olast = 1'b1;
                    n_cont  = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_pend = rd_owner;
                    n_head = head_inc;
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        n_ov    = 1'b1;
                        n_oev   = EV_WAKE;
                        n_oid   = rd_owner;
                        n_olast = 1'b1;
                        n_cont  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        mem_ra  = head_inc;
                        n_state = S_TCHK;
                    end
                end
            end
            // peek the new head to tell whether the pending wake is the last
            S_TCHK: begin
                n_ov  = 1'b1;
                n_oev = EV_WAKE;
                n_oid = r_pend;
                n_state = S_OUT;
                if (rd_delta == '0) begin
                    n_olast = 1'b0;
                    n_cont  = 1'b1;
                    n_pend  = rd_owner;
                    n_head  = head_inc;
                    n_cnt   = r_cnt - 1'b1;
                end else begin
                    n_olast = 1'b1;
                    n_cont  = 1'b0;
                end
            end
            S_TNEXT: begin
                if (r_cnt == '0) begin
                    n_ov    = 1'b1;
                    n_oev   = EV_WAKE;
                    n_oid   = r_pend;
                    n_olast = 1'b1;
                    n_cont  = 1'b0;
                    n_state = S_OUT;
                end else begin
                    mem_ra  = r_head;
                    n_state = S_TCHK;
                end
            end
            // hold the result beat until taken
            S_OUT: begin
                if (i_ready) begin
                    n_ov    = 1'b0;
                    n_state = r_cont ? S_TNEXT : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ov    = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_head  <= '0;
            r_tick  <= '0;
            r_ov    <= 1'b0;
            r_cont  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_tick  <= n_tick;
            r_ov    <= n_ov;
            r_cont  <= n_cont;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_rem   <= n_rem;
        r_id    <= n_id;
        r_pend  <= n_pend;
        r_oev   <= n_oev;
        r_oid   <= n_oid;
        r_olast <= n_olast;
    end

    // list RAM with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ov;
    assign o_event_res  = r_oev;
    assign o_woken_id   = r_oid;
    assign o_tick_count = r_tick;
    assign o_last       = r_olast;

    // a full queue must answer the add with a reject
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_command == CMD_ADD && r_cnt == CNTW'(TIMERS))
        |=> (o_valid && o_event_res == EV_REJECT && o_last))
        else $error("full queue did not reject add");

    // entry count never exceeds the capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(TIMERS))
        else $error("entry count above capacity");

    // the tick counter moves only on an accepted tick
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_valid && o_ready && i_command == CMD_TICK)) |=> $stable(r_tick))
        else $error("tick counter moved without a tick");

    // an accepted add leaves at least one entry
    a_add_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res == EV_ADD_OK) |-> (r_cnt != '0))
        else $error("accepted add left the queue empty");

    // a wake that is not the last is followed by another wake
    a_wake_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_event_res == EV_WAKE && !o_last)
        |=> (r_state == S_TNEXT))
        else $error("wake chain broken");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for delta_timer_queue_unit
// Drives add and tick beats through the valid/ready input channel, models the
// delta list in a scoreboard class and checks every result beat in order.
// Idling on both channels changes across phases of the run.
// ----------------------------------------------------------------------------
module testbench;
    import dtq_pkg::*;

    localparam int TIMERS       = 16;
    localparam int PROCESS_BITS = 6;
    localparam int RANDOM_BEATS = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_CAP   = 64;

    typedef struct {
        t_event                    ev;
        logic [PROCESS_BITS-1:0]   id;
        logic [TICK_W-1:0]         tick;
        logic                      last;
    } queue_event_t;

    // Delta-list model of the queue plus the list of result beats still owed.
    class wake_scoreboard;
        bit [DELAY_W-1:0]      deltas[TIMERS];
        bit [PROCESS_BITS-1:0] owners[TIMERS];
        int unsigned           live;
        bit [TICK_W-1:0]       ticks;
        queue_event_t          expected[$];
        int unsigned           errors;

        function void push_event(t_event ev, logic [PROCESS_BITS-1:0] id, logic last);
            queue_event_t e;
            e.ev   = ev;
            e.id   = id;
            e.tick = ticks;
            e.last = last;
            expected.push_back(e);
        endfunction

        // Update the list for one accepted beat and queue its results.
        function void note_beat(logic cmd, logic [PROCESS_BITS-1:0] id,
                                logic [DELAY_W-1:0] dly);
            longint unsigned target;
            longint unsigned sum;
            bit [DELAY_W-1:0] rem;
            int unsigned      pos;
            int unsigned      woke;
            if (cmd == CMD_ADD) begin
                if (live >= TIMERS) begin
                    push_event(EV_REJECT, '0, 1'b1);
                end else begin
                    // walk past entries expiring strictly before the new one
                    target = (dly == '0) ? 64'd1 : {32'd0, dly};
                    sum    = 0;
                    pos    = 0;
                    while (pos < live && sum + deltas[pos] < target) begin
                        sum += deltas[pos];
                        pos++;
                    end
                    rem = DELAY_W'(target - sum);
                    if (pos < live)
                        deltas[pos] -= rem;
                    for (int i = live; i > pos; i--) begin
                        deltas[i] = deltas[i-1];
                        owners[i] = owners[i-1];
                    end
                    deltas[pos] = rem;
                    owners[pos] = id;
                    live++;
                    push_event(EV_ADD_OK, '0, 1'b1);
                end
            end else begin
                ticks++;
                woke = 0;
                if (live > 0) begin
                    deltas[0]--;
                    // wake every leading entry that reached zero
                    while (live > 0 && deltas[0] == '0) begin
                        push_event(EV_WAKE, owners[0], 1'b0);
                        woke++;
                        for (int i = 1; i < live; i++) begin
                            deltas[i-1] = deltas[i];
                            owners[i-1] = owners[i];
                        end
                        live--;
                    end
                end
                if (woke == 0)
                    push_event(EV_TICK, '0, 1'b1);
                else
                    expected[expected.size()-1].last = 1'b1;
            end
        endfunction

        // Compare one result beat with the oldest expectation.
        function void check_beat(t_event ev, logic [PROCESS_BITS-1:0] id,
                                 logic [TICK_W-1:0] tick, logic last);
            queue_event_t e;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result: event %0d id %0d tick %0d last %0b",
                             $time, ev, id, tick, last);
            end else begin
                e = expected.pop_front();
                if (ev !== e.ev || id !== e.id || tick !== e.tick || last !== e.last) begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display({"%0t: mismatch: expected event %0d id %0d tick %0d last %0b,",
                                  " got event %0d id %0d tick %0d last %0b"},
                                 $time, e.ev, e.id, e.tick, e.last, ev, id, tick, last);
                end
            end
        endfunction
    endclass

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_valid      = 1'b0;
    logic                    i_command    = CMD_TICK;
    logic [PROCESS_BITS-1:0] i_process_id = '0;
    logic [DELAY_W-1:0]      i_delay      = '0;
    logic                    i_ready      = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic [EVENT_W-1:0]      o_event_res;
    logic [PROCESS_BITS-1:0] o_woken_id;
    logic [TICK_W-1:0]       o_tick_count;
    logic                    o_last;

    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    cycles         = 0;
    wake_scoreboard sb             = new;

    delta_timer_queue_unit #(
        .TIMERS       (TIMERS),
        .PROCESS_BITS (PROCESS_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_process_id (i_process_id),
        .i_delay      (i_delay),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_res  (o_event_res),
        .o_woken_id   (o_woken_id),
        .o_tick_count (o_tick_count),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // stall the result channel at the current phase's rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // note accepted input beats, then check accepted result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_beat(i_command, i_process_id, i_delay);
            if (o_valid && i_ready)
                sb.check_beat(o_event_res, o_woken_id, o_tick_count, o_last);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("delta_timer_queue_unit test failed");
            $finish;
        end
    end

    // Offer one beat and hold it until accepted; returns on the accepting edge.
    task automatic send_beat(input logic cmd, input logic [PROCESS_BITS-1:0] id,
                             input logic [DELAY_W-1:0] dly);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_process_id <= id;
        i_delay      <= dly;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // tick with junk in the unused payload fields
    task automatic send_tick();
        send_beat(CMD_TICK, PROCESS_BITS'($urandom_range(0, 63)), $urandom);
    endtask

    initial begin : main_seq
        int unsigned          sent;
        int unsigned          burst;
        int unsigned          pick;
        logic [DELAY_W-1:0]   dly;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick on an empty queue
        send_tick();
        // zero delay, then an add with an equal expiry: both wake on one tick
        send_beat(CMD_ADD, 6'd63, 32'd0);
        send_beat(CMD_ADD, 6'd0, 32'd1);
        send_tick();
        // longest delay stays in the list for the whole run
        send_beat(CMD_ADD, 6'd42, 32'hFFFF_FFFF);
        // fill the queue with equal expiries, then overflow it
        for (int k = 1; k < TIMERS; k++)
            send_beat(CMD_ADD, PROCESS_BITS'(k), 32'd2);
        send_beat(CMD_ADD, 6'd7, 32'd5);
        // age without a wake, then wake the whole batch at once
        send_tick();
        send_tick();

        // random bursts of adds and ticks under each idling phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            sent = 0;
            while (sent < RANDOM_BEATS / 4) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    burst = $urandom_range(1, 6);
                    repeat (burst) begin
                        // mostly short delays so entries expire within the run
                        pick = $urandom_range(0, 99);
                        if (pick < 10)
                            dly = '0;
                        else if (pick < 60)
                            dly = $urandom_range(1, 6);
                        else if (pick < 85)
                            dly = $urandom_range(7, 40);
                        else if (pick < 97)
                            dly = $urandom_range(41, 120);
                        else
                            dly = $urandom;
                        send_beat(CMD_ADD, PROCESS_BITS'($urandom_range(0, 63)), dly);
                    end
                end else begin
                    burst = (pick < 95) ? $urandom_range(1, 8) : 24;
                    repeat (burst) send_tick();
                end
                sent += burst;
            end
        end

        // drain: let the last beat be noted, then wait for all results
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("delta_timer_queue_unit test passed");
        else
            $display("delta_timer_queue_unit test failed");
        $finish;
    end

endmodule
